// ----- sv/mbtrh_pkg.sv -----
// Shared types and protocol constants for the Modbus TCP read-holding server.
// This package has no dependencies. The top level and its checker use it.
package mbtrh_pkg;

  // Length of the stored part of a request: the MBAP header plus the PDU head.
  localparam int unsigned HDR_LEN = 12;

  // Modbus constants.
  localparam logic [7:0]  FC_READ_HOLDING      = 8'h03;
  localparam logic [7:0]  EXC_FLAG             = 8'h80;
  localparam logic [7:0]  EXC_ILLEGAL_FUNCTION = 8'h01;
  localparam logic [7:0]  EXC_ILLEGAL_ADDRESS  = 8'h02;
  localparam logic [15:0] MAX_COUNT            = 16'd125;
  localparam logic [5:0]  MBAP_PREFIX          = 6'd6;

  // Fixed positions of response bytes.
  localparam logic [5:0] POS_TID_HI  = 6'd0;
  localparam logic [5:0] POS_TID_LO  = 6'd1;
  localparam logic [5:0] POS_PID_HI  = 6'd2;
  localparam logic [5:0] POS_PID_LO  = 6'd3;
  localparam logic [5:0] POS_LEN_HI  = 6'd4;
  localparam logic [5:0] POS_LEN_LO  = 6'd5;
  localparam logic [5:0] POS_UNIT    = 6'd6;
  localparam logic [5:0] POS_FUNC    = 6'd7;
  localparam logic [5:0] POS_DETAIL  = 6'd8;

  // Input operation codes.
  localparam logic OP_REQUEST_BYTE = 1'b0;
  localparam logic OP_WRITE_REG    = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CHECK = 3'b010,
    ST_EMIT  = 3'b100
  } state_t;

endpackage

// ----- sv/modbus_tcp_read_holding_server.sv -----
// Top level of the Modbus TCP read-holding-registers server.
// Depends on mbtrh_pkg for constants and the sequencer state type.
//
// The block accepts one word per cycle while idle: either a request byte or a write
// of one holding register. Register writes and request bytes without frame_end
// never stall. The request byte that carries frame_end starts the response: a
// request check on the shared 17-bit adder, then the response is walked one byte
// per cycle through the output register while the consumer does not stall, so a
// response of N bytes (9 for an exception, 9 + 2 * count for a normal reply) holds
// off new input until its last byte is loaded. Only the first twelve request bytes
// are kept; a short frame reuses bytes kept from earlier frames. The holding-register
// table is cleared at reset, and writes to indexes at or above NUM_REGS are ignored.
module modbus_tcp_read_holding_server #(
  parameter int unsigned NUM_REGS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_end,
  input  logic [3:0]  in_reg_index,
  input  logic [15:0] in_reg_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last
);

  localparam int unsigned IW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam logic [16:0] NREGS = 17'(NUM_REGS);

  mbtrh_pkg::state_t state_r, state_nxt;

  logic [7:0]    header_r [mbtrh_pkg::HDR_LEN];
  logic [3:0]    pos_r, pos_nxt;
  logic [15:0]   table_r  [NUM_REGS];

  logic [5:0]    k_r, k_nxt;
  logic [5:0]    last_k_r, last_k_nxt;
  logic [5:0]    len_m6_r, len_m6_nxt;
  logic [7:0]    func_byte_r, func_byte_nxt;
  logic [7:0]    detail_r, detail_nxt;
  logic [IW-1:0] ptr_r, ptr_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic          out_last_r, out_last_nxt;

  logic          accept;
  logic          is_write;
  logic          write_ok;
  logic [IW-1:0] waddr;
  logic [15:0]   req_start;
  logic [15:0]   req_qty;
  logic [16:0]   adder_out;
  logic          bad_req;
  logic          load_out;
  logic [15:0]   rd_value;
  logic [7:0]    emit_byte;

  assign in_ready  = (state_r == mbtrh_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign is_write  = (in_operation == mbtrh_pkg::OP_WRITE_REG);
  assign write_ok  = ({1'b0, 12'd0, in_reg_index} < NREGS);
  assign waddr     = IW'(in_reg_index);

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  // Request fields as stored, big-endian.
  assign req_start = {header_r[8], header_r[9]};
  assign req_qty   = {header_r[10], header_r[11]};

  // Shared adder: forms start + count while checking, and steps the table pointer
  // while the response is walked.
  always_comb begin
    if (state_r == mbtrh_pkg::ST_CHECK) begin
      adder_out = {1'b0, req_start} + {1'b0, req_qty};
    end else begin
      adder_out = 17'(ptr_r) + 17'd1;
    end
  end

  assign bad_req = ({1'b0, req_start} >= NREGS) || (adder_out > NREGS) ||
                   (req_qty == 16'd0) || (req_qty > mbtrh_pkg::MAX_COUNT);

  assign rd_value = table_r[ptr_r];
  assign load_out = (state_r == mbtrh_pkg::ST_EMIT) && (!out_valid_r || out_ready);

  // Response byte for the current position.
  always_comb begin
    case (k_r)
      mbtrh_pkg::POS_TID_HI: emit_byte = header_r[0];
      mbtrh_pkg::POS_TID_LO: emit_byte = header_r[1];
      mbtrh_pkg::POS_PID_HI: emit_byte = 8'd0;
      mbtrh_pkg::POS_PID_LO: emit_byte = 8'd0;
      mbtrh_pkg::POS_LEN_HI: emit_byte = 8'd0;
      mbtrh_pkg::POS_LEN_LO: emit_byte = {2'b00, len_m6_r};
      mbtrh_pkg::POS_UNIT:   emit_byte = header_r[6];
      mbtrh_pkg::POS_FUNC:   emit_byte = func_byte_r;
      mbtrh_pkg::POS_DETAIL: emit_byte = detail_r;
      default: begin
        // Data bytes start at an odd position, high byte first.
        emit_byte = k_r[0] ? rd_value[15:8] : rd_value[7:0];
      end
    endcase
  end

  // Sequencer and output register.
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    k_nxt         = k_r;
    last_k_nxt    = last_k_r;
    len_m6_nxt    = len_m6_r;
    func_byte_nxt = func_byte_r;
    detail_nxt    = detail_r;
    ptr_nxt       = ptr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      mbtrh_pkg::ST_IDLE: begin
        if (accept && !is_write) begin
          if (pos_r < 4'(mbtrh_pkg::HDR_LEN)) begin
            pos_nxt = pos_r + 4'd1;
          end
          if (in_frame_end) begin
            state_nxt = mbtrh_pkg::ST_CHECK;
          end
        end
      end
      mbtrh_pkg::ST_CHECK: begin
        pos_nxt = 4'd0;
        k_nxt   = 6'd0;
        ptr_nxt = IW'(req_start);
        if (header_r[7] != mbtrh_pkg::FC_READ_HOLDING) begin
          func_byte_nxt = header_r[7] | mbtrh_pkg::EXC_FLAG;
          detail_nxt    = mbtrh_pkg::EXC_ILLEGAL_FUNCTION;
          len_m6_nxt    = 6'd3;
        end else if (bad_req) begin
          func_byte_nxt = mbtrh_pkg::FC_READ_HOLDING | mbtrh_pkg::EXC_FLAG;
          detail_nxt    = mbtrh_pkg::EXC_ILLEGAL_ADDRESS;
          len_m6_nxt    = 6'd3;
        end else begin
          func_byte_nxt = mbtrh_pkg::FC_READ_HOLDING;
          detail_nxt    = {req_qty[6:0], 1'b0};
          len_m6_nxt    = {req_qty[4:0], 1'b0} + 6'd3;
        end
        last_k_nxt = len_m6_nxt + mbtrh_pkg::MBAP_PREFIX - 6'd1;
        state_nxt  = mbtrh_pkg::ST_EMIT;
      end
      mbtrh_pkg::ST_EMIT: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = emit_byte;
          out_last_nxt  = (k_r == last_k_r);
          k_nxt         = k_r + 6'd1;
          // Step to the next register after its low byte has gone out.
          if ((k_r > mbtrh_pkg::POS_DETAIL) && !k_r[0]) begin
            ptr_nxt = adder_out[IW-1:0];
          end
          if (k_r == last_k_r) begin
            state_nxt = mbtrh_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = mbtrh_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mbtrh_pkg::ST_IDLE;
      pos_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers of the response walk.
  always_ff @(posedge clk) begin
    k_r         <= k_nxt;
    last_k_r    <= last_k_nxt;
    len_m6_r    <= len_m6_nxt;
    func_byte_r <= func_byte_nxt;
    detail_r    <= detail_nxt;
    ptr_r       <= ptr_nxt;
    out_byte_r  <= out_byte_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Stored request bytes, cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < int'(mbtrh_pkg::HDR_LEN); i++) begin
        header_r[i] <= 8'd0;
      end
    end else if (accept && !is_write && (pos_r < 4'(mbtrh_pkg::HDR_LEN))) begin
      header_r[pos_r] <= in_data_byte;
    end
  end

  // Holding-register table, cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < int'(NUM_REGS); i++) begin
        table_r[i] <= 16'd0;
      end
    end else if (accept && is_write && write_ok) begin
      table_r[waddr] <= in_reg_value;
    end
  end

endmodule

// ----- sv/mbtrh_checker.sv -----
// Port-level checker for the Modbus TCP read-holding server, bound to the top level.
// Depends on mbtrh_pkg for the operation codes.
module mbtrh_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_operation,
  input logic       in_frame_end,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // A stalled response word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("response word changed while stalled");

  // A register write never stalls the input side.
  a_write_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_operation == mbtrh_pkg::OP_WRITE_REG) |=> in_ready)
    else $error("input stalled after a register write");

  // The end of a request holds off input while the response starts.
  a_frame_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_operation == mbtrh_pkg::OP_REQUEST_BYTE) && in_frame_end
    |=> !in_ready ##1 !in_ready)
    else $error("input accepted too soon after end of request");

  // Within a response, the next word follows as soon as one is taken.
  a_resp_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("gap inside a response frame");

endmodule

bind modbus_tcp_read_holding_server mbtrh_checker u_mbtrh_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_operation (in_operation),
  .in_frame_end (in_frame_end),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_byte     (out_byte),
  .out_last     (out_last)
);

// ----- test/tb_modbus_tcp_read_holding_server.sv -----
// Self-checking testbench for the Modbus TCP read-holding-registers server.
// Depends on mbtrh_pkg and modbus_tcp_read_holding_server; a predictor inside
// works out every response byte and a checker compares each accepted word.
module tb_modbus_tcp_read_holding_server;

  localparam int NUM_REGS   = 16;
  localparam int MAX_RESP   = 9 + 2 * NUM_REGS;
  localparam int CYCLE_CAP  = 400000;
  localparam int PRINT_CAP  = 50;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } resp_word_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_operation;
  logic [7:0]  in_data_byte;
  logic        in_frame_end;
  logic [3:0]  in_reg_index;
  logic [15:0] in_reg_value;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        out_last;

  // Predictor state: the kept request bytes, the next slot and the table.
  logic [7:0]  req_bytes [mbtrh_pkg::HDR_LEN];
  int          req_pos;
  logic [15:0] hold_regs [NUM_REGS];

  resp_word_t  pending_resp[$];
  resp_word_t  head_resp;
  logic [7:0]  frame_buf [16];
  int          send_idle_pct;
  int          recv_stall_pct;
  int          words_sent;
  int          errors;
  int          cycles;

  modbus_tcp_read_holding_server #(
    .NUM_REGS(NUM_REGS)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_operation(in_operation),
    .in_data_byte(in_data_byte),
    .in_frame_end(in_frame_end),
    .in_reg_index(in_reg_index),
    .in_reg_value(in_reg_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .out_last    (out_last)
  );

  // Clock generator.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("%0t: timeout with %0d response words outstanding", $time,
               pending_resp.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Apply one accepted word to the predictor and queue the response it causes.
  function automatic void predict_word(input logic op, input logic [7:0] data,
                                       input logic fend, input logic [3:0] idx,
                                       input logic [15:0] val);
    logic [7:0]  resp [MAX_RESP];
    logic [7:0]  func;
    logic [15:0] plen;
    int          len;
    int          start;
    int          count;
    resp_word_t  w;
    if (op == mbtrh_pkg::OP_WRITE_REG) begin
      if (int'(idx) < NUM_REGS) hold_regs[idx] = val;
      return;
    end
    if (req_pos < mbtrh_pkg::HDR_LEN) begin
      req_bytes[req_pos] = data;
      req_pos++;
    end
    if (!fend) return;

    // Build the response frame from the kept request bytes.
    len     = 9;
    func    = req_bytes[7];
    resp[0] = req_bytes[0];
    resp[1] = req_bytes[1];
    resp[2] = 8'h00;
    resp[3] = 8'h00;
    resp[6] = req_bytes[6];
    if (func == mbtrh_pkg::FC_READ_HOLDING) begin
      start = {req_bytes[8], req_bytes[9]};
      count = {req_bytes[10], req_bytes[11]};
      if (start >= NUM_REGS || start + count > NUM_REGS || count == 0 ||
          count > int'(mbtrh_pkg::MAX_COUNT)) begin
        resp[7] = mbtrh_pkg::FC_READ_HOLDING | mbtrh_pkg::EXC_FLAG;
        resp[8] = mbtrh_pkg::EXC_ILLEGAL_ADDRESS;
      end else begin
        resp[7] = mbtrh_pkg::FC_READ_HOLDING;
        resp[8] = 8'(count * 2);
        for (int i = 0; i < count; i++) begin
          resp[len]     = hold_regs[start + i][15:8];
          resp[len + 1] = hold_regs[start + i][7:0];
          len += 2;
        end
      end
    end else begin
      resp[7] = func | mbtrh_pkg::EXC_FLAG;
      resp[8] = mbtrh_pkg::EXC_ILLEGAL_FUNCTION;
    end
    plen    = 16'(len - int'(mbtrh_pkg::MBAP_PREFIX));
    resp[4] = plen[15:8];
    resp[5] = plen[7:0];
    for (int i = 0; i < len; i++) begin
      w.data = resp[i];
      w.last = (i == len - 1);
      pending_resp.push_back(w);
    end
    req_pos = 0;
  endfunction

  // Checker and receiver: compare each accepted word, then choose the next stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_resp.size() == 0) begin
        errors++;
        if (errors <= PRINT_CAP)
          $display("%0t: unexpected word: expected none, actual byte %02h last %0b",
                   $time, out_byte, out_last);
      end else begin
        head_resp = pending_resp.pop_front();
        if (out_byte !== head_resp.data) begin
          errors++;
          if (errors <= PRINT_CAP)
            $display("%0t: out_byte mismatch: expected %02h, actual %02h", $time,
                     head_resp.data, out_byte);
        end
        if (out_last !== head_resp.last) begin
          errors++;
          if (errors <= PRINT_CAP)
            $display("%0t: out_last mismatch: expected %0b, actual %0b", $time,
                     head_resp.last, out_last);
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Offer one word, possibly after an idle gap, and hold it until accepted.
  task automatic send_word(input logic op, input logic [7:0] data, input logic fend,
                           input logic [3:0] idx, input logic [15:0] val);
    int gap;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(4, 1);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_data_byte <= data;
    in_frame_end <= fend;
    in_reg_index <= idx;
    in_reg_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_word(op, data, fend, idx, val);
    words_sent++;
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [15:0] val,
                           input logic fend);
    send_word(mbtrh_pkg::OP_WRITE_REG, 8'($urandom), fend, idx, val);
  endtask

  // Send the first nbytes of frame_buf as one request frame.
  task automatic send_frame(input int nbytes);
    for (int i = 0; i < nbytes; i++)
      send_word(mbtrh_pkg::OP_REQUEST_BYTE, frame_buf[i], i == nbytes - 1,
                4'($urandom), 16'($urandom));
  endtask

  // Lay out a request in frame_buf; the bytes past the twelfth are noise.
  task automatic load_request(input logic [15:0] tid, input logic [7:0] unit_id,
                              input logic [7:0] fc, input logic [15:0] start,
                              input logic [15:0] count);
    frame_buf[0]  = tid[15:8];
    frame_buf[1]  = tid[7:0];
    frame_buf[2]  = 8'h00;
    frame_buf[3]  = 8'h00;
    frame_buf[4]  = 8'h00;
    frame_buf[5]  = 8'h06;
    frame_buf[6]  = unit_id;
    frame_buf[7]  = fc;
    frame_buf[8]  = start[15:8];
    frame_buf[9]  = start[7:0];
    frame_buf[10] = count[15:8];
    frame_buf[11] = count[7:0];
    for (int i = 12; i < 16; i++) frame_buf[i] = 8'($urandom);
  endtask

  // Wait for every predicted word, then let the block settle.
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // A one-byte frame straight after reset sees a header that is zero but for its first byte.
  task automatic test_reset_frame;
    frame_buf[0] = 8'h5A;
    send_frame(1);
  endtask

  // Table writes, a write carrying frame_end, and the longest reply, sent
  // as an overlong frame.
  task automatic test_register_reads;
    write_reg(4'd0, 16'hFFFF, 1'b0);
    write_reg(4'd15, 16'h8001, 1'b1);
    write_reg(4'd8, 16'hA55A, 1'b0);
    load_request(16'hFFFF, 8'hFF, mbtrh_pkg::FC_READ_HOLDING, 16'd0, 16'(NUM_REGS));
    send_frame(14);
  endtask

  // Start out of range (short frame reusing the stored count), overrun, zero count.
  task automatic test_address_errors;
    frame_buf[8] = 8'h00;
    frame_buf[9] = 8'(NUM_REGS);
    send_frame(10);
    load_request(16'h1234, 8'h01, mbtrh_pkg::FC_READ_HOLDING, 16'd10, 16'd7);
    send_frame(12);
    load_request(16'h0000, 8'h00, mbtrh_pkg::FC_READ_HOLDING, 16'd0, 16'd0);
    send_frame(12);
  endtask

  // Unsupported function codes, each sent as a short frame.
  task automatic test_function_errors;
    load_request(16'h5678, 8'h02, 8'h04, 16'd0, 16'd1);
    send_frame(8);
    frame_buf[7] = 8'hFF;
    send_frame(8);
  endtask

  // One random frame, preceded by up to three table writes.
  task automatic random_frame;
    int          kind;
    int          lr;
    int          nbytes;
    int          start;
    int          count;
    logic [7:0]  fc;
    repeat ($urandom_range(3)) write_reg(4'($urandom), 16'($urandom), 1'($urandom));
    kind  = $urandom_range(99);
    fc    = mbtrh_pkg::FC_READ_HOLDING;
    start = $urandom_range(NUM_REGS - 1);
    if (kind < 70) begin
      // Well-formed read, mostly short so that responses stay brief.
      if ($urandom_range(99) < 15) count = $urandom_range(NUM_REGS - start, 1);
      else count = $urandom_range((NUM_REGS - start < 4) ? NUM_REGS - start : 4, 1);
    end else if (kind < 85) begin
      case ($urandom_range(3))
        0: begin
          start = $urandom_range(65535, NUM_REGS);
          count = $urandom_range(8, 1);
        end
        1: count = $urandom_range(65535, NUM_REGS - start + 1);
        2: count = 0;
        default: begin
          start = $urandom_range(65535);
          count = $urandom_range(65535, 126);
        end
      endcase
    end else begin
      fc    = 8'($urandom);
      count = $urandom_range(65535);
    end
    load_request(16'($urandom), 8'($urandom), fc, 16'(start), 16'(count));
    frame_buf[2] = 8'($urandom_range(99) < 10 ? $urandom : 0);
    frame_buf[3] = 8'($urandom_range(99) < 10 ? $urandom : 0);
    if (kind >= 95)
      for (int i = 0; i < 12; i++) frame_buf[i] = 8'($urandom);
    lr = $urandom_range(99);
    if (lr < 80) nbytes = 12;
    else if (lr < 92) nbytes = $urandom_range(16, 13);
    else nbytes = $urandom_range(11, 1);
    send_frame(nbytes);
  endtask

  // Random traffic under four idling patterns on the two channels.
  task automatic test_random_traffic;
    int phase_end;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      phase_end = words_sent + 42;
      while (words_sent < phase_end) random_frame();
    end
  endtask

  // Reset, then the tests in turn, then the verdict.
  initial begin
    for (int i = 0; i < mbtrh_pkg::HDR_LEN; i++) req_bytes[i] = 8'h00;
    for (int i = 0; i < NUM_REGS; i++) hold_regs[i] = 16'h0000;
    req_pos        = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    words_sent     = 0;
    errors         = 0;
    cycles         = 0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_operation <= mbtrh_pkg::OP_REQUEST_BYTE;
    in_data_byte <= 8'h00;
    in_frame_end <= 1'b0;
    in_reg_index <= 4'h0;
    in_reg_value <= 16'h0000;
    out_ready    <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_frame();
    test_register_reads();
    test_address_errors();
    test_function_errors();
    test_random_traffic();
    drain();

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
